@@ sv/biquad_filter_with_wet_dry_mix_defines.svh @@
// Assertion macros for the biquad wet/dry mix block.
// No dependencies; taken in by the files that assert.
`ifndef BIQUAD_FILTER_WITH_WET_DRY_MIX_DEFINES_SVH
`define BIQUAD_FILTER_WITH_WET_DRY_MIX_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define BQMIX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqmix check failed");

// Next-cycle implication, quiet during reset.
`define BQMIX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqmix check failed");

`endif

@@ sv/bqmix_pkg.sv @@
// Types, constants and microcode ROM of the biquad wet/dry mix block.
// No dependencies; used by the top level.
`default_nettype none

package bqmix_pkg;

    localparam int MIX_W     = 16;
    localparam int MIX_FRAC  = 15;
    localparam logic [MIX_W-1:0] MIX_ONE = 16'h8000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FF0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FF2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WET = 3'd5;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_ACCEPT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST   = 4'd10;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JUMP
    } t_seq;

    typedef enum logic [3:0] {
        A_NONE, A_FF0, A_FF1, A_FF2, A_FB1, A_FB2, A_DRY, A_SLO, A_SHI
    } t_a_sel;

    typedef enum logic [2:0] {
        B_NONE, B_X, B_X1, B_X2, B_Y1, B_Y2, B_MIX
    } t_b_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc_op;

    typedef enum logic [1:0] {
        T_HOLD, T_LOAD_DRY, T_ADD_LO, T_ADD_HI
    } t_mix_op;

    typedef struct packed {
        t_seq              seq;
        logic [STEP_W-1:0] tgt;
        t_a_sel            a_sel;
        t_b_sel            b_sel;
        t_acc_op           acc_op;
        t_mix_op           mix_op;
    } t_cword;

    // Product issued at step n is consumed by the accumulate or mix field of step n+1.
    function automatic t_cword bqmix_ucode(input logic [STEP_W-1:0] step);
        t_cword cw;
        cw = '{SEQ_NEXT, STEP_ACCEPT, A_NONE, B_NONE, ACC_HOLD, T_HOLD};
        unique case (step)
            4'd0:  cw.seq = SEQ_WAIT_IN;
            4'd1:  begin cw.a_sel = A_FF0; cw.b_sel = B_X; end
            4'd2:  begin cw.a_sel = A_FF1; cw.b_sel = B_X1; cw.acc_op = ACC_LOAD; end
            4'd3:  begin cw.a_sel = A_FF2; cw.b_sel = B_X2; cw.acc_op = ACC_ADD; end
            4'd4:  begin cw.a_sel = A_FB1; cw.b_sel = B_Y1; cw.acc_op = ACC_ADD; end
            4'd5:  begin cw.a_sel = A_FB2; cw.b_sel = B_Y2; cw.acc_op = ACC_SUB; end
            4'd6:  begin cw.a_sel = A_DRY; cw.b_sel = B_X;  cw.acc_op = ACC_SUB; end
            4'd7:  begin cw.a_sel = A_SLO; cw.b_sel = B_MIX; cw.mix_op = T_LOAD_DRY; end
            4'd8:  begin cw.a_sel = A_SHI; cw.b_sel = B_MIX; cw.mix_op = T_ADD_LO; end
            4'd9:  cw.mix_op = T_ADD_HI;
            4'd10: begin cw.seq = SEQ_WAIT_OUT; cw.tgt = STEP_ACCEPT; end
            default: begin cw.seq = SEQ_JUMP; cw.tgt = STEP_ACCEPT; end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

@@ sv/bqmix_if.sv @@
// Handshake channels of the biquad wet/dry mix block: sample in, result out.
// No dependencies.
`default_nettype none

interface bqmix_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqmix_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

@@ sv/biquad_filter_with_wet_dry_mix.sv @@
// Direct form I biquad with wet/dry mix, run by a microcoded sequencer.
// Depends on bqmix_pkg, bqmix_if.sv and biquad_filter_with_wet_dry_mix_defines.svh.
//
//  channel   | dir | handshake           | word
//  ----------+-----+---------------------+-------------------------------
//  i_in      | in  | valid/ready         | sample_in, signed Q1.23
//  o_out     | out | valid/ready         | sample_out (Q1.23), clipped
//  i_cfg_*   | in  | write enable only   | register index, data
//
// Each sample runs through an accept step, then ten microcode steps; eight
// issue products on one registered multiplier (five taps, the dry product, two
// limbs of the wet scaling), one folds in the last limb, and the last rounds,
// saturates and loads the output register.
// Reset clears the step counter, delay lines and coefficients, holds the input
// not ready; wet mix is 1.0.
// A stalled output holds the sequencer in its final step; the next sample is
// accepted while a finished word still waits in the output register.
`default_nettype none
`include "biquad_filter_with_wet_dry_mix_defines.svh"

module biquad_filter_with_wet_dry_mix #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32,
    localparam int CFG_W = (COEF_BITS > bqmix_pkg::MIX_W) ? COEF_BITS : bqmix_pkg::MIX_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bqmix_in_if.sink                         i_in,
    bqmix_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [bqmix_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]                 i_cfg_data
);
    import bqmix_pkg::*;

    // Fixed-point layout
    localparam int CF  = COEF_BITS - 4;              // coefficient fraction bits
    localparam int RS  = CF + MIX_FRAC;              // final rounding shift
    localparam int AW  = COEF_BITS + SAMPLE_BITS + 3; // biquad sum, five products
    localparam int HL  = (AW + 1) / 2;               // low limb of the sum, unsigned
    localparam int MA0 = (COEF_BITS > HL + 1) ? COEF_BITS : HL + 1;
    localparam int MA  = (MA0 > MIX_W + 1) ? MA0 : MIX_W + 1;
    localparam int MB  = (SAMPLE_BITS > MIX_W + 1) ? SAMPLE_BITS : MIX_W + 1;
    localparam int PW  = MA + MB;
    localparam int TW  = AW + MIX_W + 2;             // mixed total before rounding
    localparam int QW  = TW - RS;
    localparam logic signed [TW-1:0] HALF = TW'(1) <<< (RS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration
    logic signed [COEF_BITS-1:0] r_ff0, r_ff1, r_ff2, r_fb1, r_fb2;
    logic [MIX_W-1:0]            r_wet;
    logic [MIX_W-1:0]            dry;

    // Filter state and datapath
    logic signed [SAMPLE_BITS-1:0] r_x, r_x1, r_x2, r_y1, r_y2;
    logic [STEP_W-1:0]             r_step, n_step;
    logic signed [MA-1:0]          mul_a;
    logic signed [MB-1:0]          mul_b;
    logic signed [PW-1:0]          r_prod;
    logic signed [AW-1:0]          r_acc, n_acc;
    logic signed [TW-1:0]          r_t, n_t;
    logic signed [QW-1:0]          q;
    logic [QW-SAMPLE_BITS:0]       q_top;
    logic                          in_range;
    logic signed [SAMPLE_BITS-1:0] y;

    // Output register
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_osample;
    logic                          r_oclip;

    t_cword cw;
    logic   in_acc;
    logic   out_free;
    logic   out_load;

    assign cw       = bqmix_ucode(r_step);
    assign dry      = MIX_ONE - r_wet;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign out_load = (cw.seq == SEQ_WAIT_OUT) && out_free;

    // hold the input off while reset is applied
    assign i_in.ready       = i_rst_n && (cw.seq == SEQ_WAIT_IN);
    assign o_out.valid      = r_ovalid;
    assign o_out.sample_out = r_osample;
    assign o_out.clipped    = r_oclip;

    // Multiplier operand select
    always_comb begin
        unique case (cw.a_sel)
            A_FF0:   mul_a = MA'(r_ff0);
            A_FF1:   mul_a = MA'(r_ff1);
            A_FF2:   mul_a = MA'(r_ff2);
            A_FB1:   mul_a = MA'(r_fb1);
            A_FB2:   mul_a = MA'(r_fb2);
            A_DRY:   mul_a = MA'($signed({1'b0, dry}));
            A_SLO:   mul_a = MA'($signed({1'b0, r_acc[HL-1:0]}));
            A_SHI:   mul_a = MA'($signed(r_acc[AW-1:HL]));
            default: mul_a = '0;
        endcase
        unique case (cw.b_sel)
            B_X:     mul_b = MB'(r_x);
            B_X1:    mul_b = MB'(r_x1);
            B_X2:    mul_b = MB'(r_x2);
            B_Y1:    mul_b = MB'(r_y1);
            B_Y2:    mul_b = MB'(r_y2);
            B_MIX:   mul_b = MB'($signed({1'b0, r_wet}));
            default: mul_b = '0;
        endcase
    end

    // Accumulate the previous step's product
    always_comb begin
        unique case (cw.acc_op)
            ACC_HOLD: n_acc = r_acc;
            ACC_LOAD: n_acc = AW'(r_prod);
            ACC_ADD:  n_acc = r_acc + AW'(r_prod);
            ACC_SUB:  n_acc = r_acc - AW'(r_prod);
        endcase
        unique case (cw.mix_op)
            T_HOLD:     n_t = r_t;
            T_LOAD_DRY: n_t = (TW'(r_prod) <<< CF) + HALF;
            T_ADD_LO:   n_t = r_t + TW'(r_prod);
            T_ADD_HI:   n_t = r_t + (TW'(r_prod) <<< HL);
        endcase
    end

    // Round (half already added) and saturate
    always_comb begin
        q        = r_t[TW-1:RS];
        q_top    = q[QW-1:SAMPLE_BITS-1];
        in_range = (&q_top) || !(|q_top);
        if (in_range) begin
            y = q[SAMPLE_BITS-1:0];
        end else begin
            y = q[QW-1] ? SMIN : SMAX;
        end
    end

    // Sequencer: advance, wait on a handshake, or jump
    always_comb begin
        unique case (cw.seq)
            SEQ_NEXT:     n_step = r_step + 1'b1;
            SEQ_WAIT_IN:  n_step = in_acc ? r_step + 1'b1 : r_step;
            SEQ_WAIT_OUT: n_step = out_free ? cw.tgt : r_step;
            SEQ_JUMP:     n_step = cw.tgt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_ACCEPT;
            r_ovalid <= 1'b0;
            r_ff0    <= '0;
            r_ff1    <= '0;
            r_ff2    <= '0;
            r_fb1    <= '0;
            r_fb2    <= '0;
            r_wet    <= MIX_ONE;
            r_x1     <= '0;
            r_x2     <= '0;
            r_y1     <= '0;
            r_y2     <= '0;
        end else begin
            r_step <= n_step;
            if (out_load) begin
                r_ovalid <= 1'b1;
                // shift the delay lines with the saturated, mixed output
                r_x2     <= r_x1;
                r_x1     <= r_x;
                r_y2     <= r_y1;
                r_y1     <= y;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FF0: r_ff0 <= i_cfg_data[COEF_BITS-1:0];
                    CFG_FF1: r_ff1 <= i_cfg_data[COEF_BITS-1:0];
                    CFG_FF2: r_ff2 <= i_cfg_data[COEF_BITS-1:0];
                    CFG_FB1: r_fb1 <= i_cfg_data[COEF_BITS-1:0];
                    CFG_FB2: r_fb2 <= i_cfg_data[COEF_BITS-1:0];
                    CFG_WET: begin
                        // clamp the wet fraction to one
                        r_wet <= (i_cfg_data[MIX_W-1:0] > MIX_ONE) ?
                                 MIX_ONE : i_cfg_data[MIX_W-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_in.sample_in;
        end
        r_prod <= mul_a * mul_b;
        r_acc  <= n_acc;
        r_t    <= n_t;
        if (out_load) begin
            r_osample <= y;
            r_oclip   <= !in_range;
        end
    end

    `BQMIX_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_step == STEP_ACCEPT + 1'b1)
    `BQMIX_ASSERT_NEXT(a_load_returns, i_clk, i_rst_n, out_load, r_ovalid && r_step == STEP_ACCEPT)
    `BQMIX_ASSERT_NOW(a_clip_rails, i_clk, i_rst_n, r_ovalid && r_oclip, r_osample == SMAX || r_osample == SMIN)
    `BQMIX_ASSERT_NOW(a_step_range, i_clk, i_rst_n, 1'b1, r_step <= STEP_LAST && r_wet <= MIX_ONE)

endmodule

`default_nettype wire
